// ===== rtl/core/tjpd_pkg.sv =====
`default_nettype none

package tjpd_pkg;

    localparam int DATA_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 8;
    localparam int ERR_W      = DATA_W + 1;
    localparam int PROD_W     = GAIN_W + 1 + ERR_W;
    localparam int DIFF_W     = PROD_W + 1;
    localparam int OUT_W      = 24;
    localparam int THR_W      = 34;
    localparam int ESQ_W      = 2 * DATA_W + 1;
    localparam int RSQ_W      = 2 * DATA_W - 1;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = THR_W;

    localparam logic [GAIN_W-1:0] GAIN_P_RESET = GAIN_W'(5120);
    localparam logic [GAIN_W-1:0] GAIN_D_RESET = GAIN_W'(256);

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_1      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_2      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_1      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_2      = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_VEL_THRESH_SQ = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_ERR_THRESH_SQ = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_RATE_1 = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_RATE_2 = CFG_IDX_W'(7);

    localparam logic MODE_GOAL   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/core/two_joint_pd_goal_controller_unit.sv =====
// Two-joint PD goal regulator.
// Input channel (i_in_valid / o_in_stall) carries one beat per item. A goal beat
// (mode 0) loads both target angles and arms the regulator; it gives no result.
// A sample beat (mode 1) while armed gives one result beat on the output channel
// (o_out_valid / i_out_stall) with both drive commands, or zero drives and
// key_press set when rate and error norms are both within their thresholds,
// which also disarms the regulator. Samples while disarmed give no result.
// The datapath is three register stages: input register, product register and
// result register. One item can be accepted every cycle while no result waits
// on a stalled receiver.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// o_in_stall is raised in the same cycle; nothing is dropped.
// The configuration channel (i_cfg_valid / o_cfg_ready) is always ready and
// writes one register per beat; indexes past the register list are ignored.
// Reset clears the pipeline, disarms the regulator, zeroes the targets and
// restores the default gains and thresholds.
`default_nettype none

module two_joint_pd_goal_controller_unit (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,

    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [tjpd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [tjpd_pkg::CFG_DATA_W-1:0]      i_cfg_data,

    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic                                 i_mode,
    input  wire logic signed [tjpd_pkg::DATA_W-1:0]   i_goal_angle_1,
    input  wire logic signed [tjpd_pkg::DATA_W-1:0]   i_goal_angle_2,
    input  wire logic signed [tjpd_pkg::DATA_W-1:0]   i_joint_angle_1,
    input  wire logic signed [tjpd_pkg::DATA_W-1:0]   i_joint_angle_2,
    input  wire logic signed [tjpd_pkg::DATA_W-1:0]   i_joint_rate_1,
    input  wire logic signed [tjpd_pkg::DATA_W-1:0]   i_joint_rate_2,

    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic signed [tjpd_pkg::OUT_W-1:0]         o_drive_1,
    output logic signed [tjpd_pkg::OUT_W-1:0]         o_drive_2,
    output logic                                      o_key_press
);

    localparam int DW  = tjpd_pkg::DATA_W;
    localparam int GW  = tjpd_pkg::GAIN_W;
    localparam int EW  = tjpd_pkg::ERR_W;
    localparam int PW  = tjpd_pkg::PROD_W;
    localparam int XW  = tjpd_pkg::DIFF_W;
    localparam int OW  = tjpd_pkg::OUT_W;
    localparam int TW  = tjpd_pkg::THR_W;
    localparam int QW  = tjpd_pkg::ESQ_W;
    localparam int RW  = tjpd_pkg::RSQ_W;
    localparam int GF  = tjpd_pkg::GAIN_FRAC;
    localparam int SW  = XW - GF;

    // Configuration registers.
    logic [GW-1:0]        r_gain_p_1, r_gain_p_2, r_gain_d_1, r_gain_d_2;
    logic [TW-1:0]        r_vel_thresh_sq, r_err_thresh_sq;
    logic signed [DW-1:0] r_target_rate_1, r_target_rate_2;

    // Regulator state.
    logic                 r_goal_done;
    logic signed [DW-1:0] r_target_angle_1, r_target_angle_2;

    // Input register.
    logic                 r_s1_valid, r_s1_mode;
    logic signed [DW-1:0] r_s1_goal_1, r_s1_goal_2;
    logic signed [DW-1:0] r_s1_angle_1, r_s1_angle_2;
    logic signed [DW-1:0] r_s1_rate_1, r_s1_rate_2;

    // Product register.
    logic                 r_s2_valid, r_s2_mode;
    logic [QW-1:0]        r_s2_esq_1, r_s2_esq_2;
    logic [RW-1:0]        r_s2_rsq_1, r_s2_rsq_2;
    logic signed [PW-1:0] r_s2_pp_1, r_s2_pp_2, r_s2_dp_1, r_s2_dp_2;

    // Result register.
    logic                 r_out_valid;
    logic signed [OW-1:0] r_drive_1, r_drive_2;
    logic                 r_key_press;

    logic                 adv;

    logic signed [EW-1:0]    n_err_1, n_err_2, n_rerr_1, n_rerr_2;
    logic signed [2*EW-1:0]  n_esq_full_1, n_esq_full_2;
    logic signed [2*DW-1:0]  n_rsq_full_1, n_rsq_full_2;
    logic signed [PW-1:0]    n_pp_1, n_pp_2, n_dp_1, n_dp_2;

    logic [TW-1:0]           n_vsq, n_esq;
    logic                    n_keep;
    logic signed [XW-1:0]    n_diff_1, n_diff_2;
    logic signed [SW-1:0]    n_scaled_1, n_scaled_2;
    logic signed [OW-1:0]    n_sat_1, n_sat_2;
    logic                    n_out_valid;
    logic signed [OW-1:0]    n_drive_1, n_drive_2;
    logic                    n_key_press;

    localparam logic signed [OW-1:0] OUT_MAX = {1'b0, {(OW-1){1'b1}}};
    localparam logic signed [OW-1:0] OUT_MIN = {1'b1, {(OW-1){1'b0}}};

    assign adv         = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !adv;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid = r_out_valid;
    assign o_drive_1   = r_drive_1;
    assign o_drive_2   = r_drive_2;
    assign o_key_press = r_key_press;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p_1      <= tjpd_pkg::GAIN_P_RESET;
            r_gain_p_2      <= tjpd_pkg::GAIN_P_RESET;
            r_gain_d_1      <= tjpd_pkg::GAIN_D_RESET;
            r_gain_d_2      <= tjpd_pkg::GAIN_D_RESET;
            r_vel_thresh_sq <= '0;
            r_err_thresh_sq <= '0;
            r_target_rate_1 <= '0;
            r_target_rate_2 <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tjpd_pkg::REG_GAIN_P_1:      r_gain_p_1      <= i_cfg_data[GW-1:0];
                tjpd_pkg::REG_GAIN_P_2:      r_gain_p_2      <= i_cfg_data[GW-1:0];
                tjpd_pkg::REG_GAIN_D_1:      r_gain_d_1      <= i_cfg_data[GW-1:0];
                tjpd_pkg::REG_GAIN_D_2:      r_gain_d_2      <= i_cfg_data[GW-1:0];
                tjpd_pkg::REG_VEL_THRESH_SQ: r_vel_thresh_sq <= i_cfg_data[TW-1:0];
                tjpd_pkg::REG_ERR_THRESH_SQ: r_err_thresh_sq <= i_cfg_data[TW-1:0];
                tjpd_pkg::REG_TARGET_RATE_1: r_target_rate_1 <= i_cfg_data[DW-1:0];
                tjpd_pkg::REG_TARGET_RATE_2: r_target_rate_2 <= i_cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    // Errors, squares and gain products.
    always_comb begin
        n_err_1  = EW'(r_target_angle_1) - EW'(r_s1_angle_1);
        n_err_2  = EW'(r_target_angle_2) - EW'(r_s1_angle_2);
        n_rerr_1 = EW'(r_target_rate_1) - EW'(r_s1_rate_1);
        n_rerr_2 = EW'(r_target_rate_2) - EW'(r_s1_rate_2);

        n_esq_full_1 = n_err_1 * n_err_1;
        n_esq_full_2 = n_err_2 * n_err_2;
        n_rsq_full_1 = r_s1_rate_1 * r_s1_rate_1;
        n_rsq_full_2 = r_s1_rate_2 * r_s1_rate_2;

        n_pp_1 = $signed({1'b0, r_gain_p_1}) * n_err_1;
        n_pp_2 = $signed({1'b0, r_gain_p_2}) * n_err_2;
        n_dp_1 = $signed({1'b0, r_gain_d_1}) * n_rerr_1;
        n_dp_2 = $signed({1'b0, r_gain_d_2}) * n_rerr_2;
    end

    // Norm check, floor scaling and saturation.
    always_comb begin
        n_vsq  = TW'(r_s2_rsq_1) + TW'(r_s2_rsq_2);
        n_esq  = TW'(r_s2_esq_1) + TW'(r_s2_esq_2);
        n_keep = (n_vsq > r_vel_thresh_sq) || (n_esq > r_err_thresh_sq);

        n_diff_1   = XW'(r_s2_pp_1) - XW'(r_s2_dp_1);
        n_diff_2   = XW'(r_s2_pp_2) - XW'(r_s2_dp_2);
        n_scaled_1 = n_diff_1[XW-1:GF];
        n_scaled_2 = n_diff_2[XW-1:GF];

        if (n_scaled_1 > SW'(OUT_MAX)) begin
            n_sat_1 = OUT_MAX;
        end else if (n_scaled_1 < SW'(OUT_MIN)) begin
            n_sat_1 = OUT_MIN;
        end else begin
            n_sat_1 = n_scaled_1[OW-1:0];
        end
        if (n_scaled_2 > SW'(OUT_MAX)) begin
            n_sat_2 = OUT_MAX;
        end else if (n_scaled_2 < SW'(OUT_MIN)) begin
            n_sat_2 = OUT_MIN;
        end else begin
            n_sat_2 = n_scaled_2[OW-1:0];
        end

        n_out_valid = r_s2_valid && (r_s2_mode == tjpd_pkg::MODE_SAMPLE) && !r_goal_done;
        n_drive_1   = n_keep ? n_sat_1 : '0;
        n_drive_2   = n_keep ? n_sat_2 : '0;
        n_key_press = !n_keep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid       <= 1'b0;
            r_s2_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_goal_done      <= 1'b1;
            r_target_angle_1 <= '0;
            r_target_angle_2 <= '0;
        end else if (adv) begin
            r_s1_valid  <= i_in_valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= n_out_valid;
            if (r_s1_valid && (r_s1_mode == tjpd_pkg::MODE_GOAL)) begin
                r_target_angle_1 <= r_s1_goal_1;
                r_target_angle_2 <= r_s1_goal_2;
            end
            if (r_s2_valid && (r_s2_mode == tjpd_pkg::MODE_GOAL)) begin
                r_goal_done <= 1'b0;
            end else if (n_out_valid && n_key_press) begin
                r_goal_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_mode    <= i_mode;
            r_s1_goal_1  <= i_goal_angle_1;
            r_s1_goal_2  <= i_goal_angle_2;
            r_s1_angle_1 <= i_joint_angle_1;
            r_s1_angle_2 <= i_joint_angle_2;
            r_s1_rate_1  <= i_joint_rate_1;
            r_s1_rate_2  <= i_joint_rate_2;

            r_s2_mode  <= r_s1_mode;
            r_s2_esq_1 <= n_esq_full_1[QW-1:0];
            r_s2_esq_2 <= n_esq_full_2[QW-1:0];
            r_s2_rsq_1 <= n_rsq_full_1[RW-1:0];
            r_s2_rsq_2 <= n_rsq_full_2[RW-1:0];
            r_s2_pp_1  <= n_pp_1;
            r_s2_pp_2  <= n_pp_2;
            r_s2_dp_1  <= n_dp_1;
            r_s2_dp_2  <= n_dp_2;

            r_drive_1   <= n_drive_1;
            r_drive_2   <= n_drive_2;
            r_key_press <= n_key_press;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tjpd_checker.sv =====
`default_nettype none

module tjpd_checker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 o_in_stall,
    input  wire logic                                 o_out_valid,
    input  wire logic                                 i_out_stall,
    input  wire logic signed [tjpd_pkg::OUT_W-1:0]    o_drive_1,
    input  wire logic signed [tjpd_pkg::OUT_W-1:0]    o_drive_2,
    input  wire logic                                 o_key_press
);

    // A goal-reached beat always carries zero drives.
    a_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_key_press) |-> (o_drive_1 == '0 && o_drive_2 == '0))
        else $error("key press beat with nonzero drive");

    // The input side only stalls behind a waiting, stalled result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_drive_1) && $stable(o_drive_2)
             && $stable(o_key_press)))
        else $error("stalled result beat changed");

endmodule

bind two_joint_pd_goal_controller_unit tjpd_checker u_tjpd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_drive_1   (o_drive_1),
    .o_drive_2   (o_drive_2),
    .o_key_press (o_key_press)
);

`default_nettype wire

// ===== sim/pd_check_pkg.sv =====
package pd_check_pkg;

    import tjpd_pkg::*;

    localparam longint MAG_LIMIT = longint'(1) << 20;
    localparam longint DRIVE_MAX = (longint'(1) << (OUT_W - 1)) - 1;
    localparam longint DRIVE_MIN = -(longint'(1) << (OUT_W - 1));

    typedef struct {
        logic                      mode;
        logic signed [DATA_W-1:0]  goal_angle_1;
        logic signed [DATA_W-1:0]  goal_angle_2;
        logic signed [DATA_W-1:0]  joint_angle_1;
        logic signed [DATA_W-1:0]  joint_angle_2;
        logic signed [DATA_W-1:0]  joint_rate_1;
        logic signed [DATA_W-1:0]  joint_rate_2;
    } pd_beat_t;

    typedef struct {
        logic signed [OUT_W-1:0] drive_1;
        logic signed [OUT_W-1:0] drive_2;
        logic                    key_press;
    } pd_command_t;

    class drive_scoreboard;
        logic [GAIN_W-1:0]        gain_p_1, gain_p_2, gain_d_1, gain_d_2;
        logic [THR_W-1:0]         vel_limit_sq, err_limit_sq;
        logic signed [DATA_W-1:0] want_rate_1, want_rate_2;
        bit                       armed;
        logic signed [DATA_W-1:0] aim_1, aim_2;
        pd_command_t              pending_drives[$];
        int                       errors;

        function new();
            gain_p_1     = GAIN_P_RESET;
            gain_p_2     = GAIN_P_RESET;
            gain_d_1     = GAIN_D_RESET;
            gain_d_2     = GAIN_D_RESET;
            vel_limit_sq = '0;
            err_limit_sq = '0;
            want_rate_1  = '0;
            want_rate_2  = '0;
            armed        = 1'b0;
            aim_1        = '0;
            aim_2        = '0;
            errors       = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_GAIN_P_1:      gain_p_1 = data[GAIN_W-1:0];
                REG_GAIN_P_2:      gain_p_2 = data[GAIN_W-1:0];
                REG_GAIN_D_1:      gain_d_1 = data[GAIN_W-1:0];
                REG_GAIN_D_2:      gain_d_2 = data[GAIN_W-1:0];
                REG_VEL_THRESH_SQ: vel_limit_sq = data[THR_W-1:0];
                REG_ERR_THRESH_SQ: err_limit_sq = data[THR_W-1:0];
                REG_TARGET_RATE_1: want_rate_1 = data[DATA_W-1:0];
                REG_TARGET_RATE_2: want_rate_2 = data[DATA_W-1:0];
                default: ;
            endcase
        endfunction

        function longint square_clamped(longint x);
            longint m;
            m = (x < 0) ? -x : x;
            if (m > MAG_LIMIT)
                m = MAG_LIMIT;
            return m * m;
        endfunction

        // The arithmetic shift of a signed value rounds toward minus infinity.
        function logic signed [OUT_W-1:0] floor_saturate(longint x);
            longint q;
            q = x >>> GAIN_FRAC;
            if (q > DRIVE_MAX)
                q = DRIVE_MAX;
            if (q < DRIVE_MIN)
                q = DRIVE_MIN;
            return q[OUT_W-1:0];
        endfunction

        function bit note_beat(pd_beat_t b);
            longint      e1, e2, r1, r2, rate_sq, err_sq, d1, d2;
            pd_command_t c;
            if (b.mode == MODE_GOAL) begin
                aim_1 = b.goal_angle_1;
                aim_2 = b.goal_angle_2;
                armed = 1'b1;
                return 1'b1;
            end
            if (!armed)
                return 1'b0;
            e1 = longint'(aim_1) - longint'(b.joint_angle_1);
            e2 = longint'(aim_2) - longint'(b.joint_angle_2);
            r1 = longint'(b.joint_rate_1);
            r2 = longint'(b.joint_rate_2);
            rate_sq = square_clamped(r1) + square_clamped(r2);
            err_sq  = square_clamped(e1) + square_clamped(e2);
            if (rate_sq > longint'(vel_limit_sq) || err_sq > longint'(err_limit_sq)) begin
                d1 = longint'(gain_p_1) * e1
                   - longint'(gain_d_1) * (longint'(want_rate_1) - r1);
                d2 = longint'(gain_p_2) * e2
                   - longint'(gain_d_2) * (longint'(want_rate_2) - r2);
                c.drive_1   = floor_saturate(d1);
                c.drive_2   = floor_saturate(d2);
                c.key_press = 1'b0;
            end else begin
                c.drive_1   = '0;
                c.drive_2   = '0;
                c.key_press = 1'b1;
                armed       = 1'b0;
            end
            pending_drives.push_back(c);
            return 1'b1;
        endfunction

        function void check_drive(pd_command_t got);
            pd_command_t want;
            if (pending_drives.size() == 0) begin
                $error("result beat with nothing expected: drive_1=%0d drive_2=%0d key_press=%0b",
                       got.drive_1, got.drive_2, got.key_press);
                errors++;
                return;
            end
            want = pending_drives.pop_front();
            if (got.drive_1 !== want.drive_1) begin
                $error("drive_1: expected %0d, got %0d", want.drive_1, got.drive_1);
                errors++;
            end
            if (got.drive_2 !== want.drive_2) begin
                $error("drive_2: expected %0d, got %0d", want.drive_2, got.drive_2);
                errors++;
            end
            if (got.key_press !== want.key_press) begin
                $error("key_press: expected %0b, got %0b", want.key_press, got.key_press);
                errors++;
            end
        endfunction
    endclass

endpackage

// ===== sim/tb_top.sv =====
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import tjpd_pkg::*;
    import pd_check_pkg::*;

    localparam int               RESET_CYCLES  = 4;
    localparam int               SETTLE_CYCLES = 8;
    localparam int               HOLD_CYCLES   = 200;
    localparam int               LIMIT_CYCLES  = 400000;
    localparam int               PHASE_ITEMS   = 225;
    localparam logic [THR_W-1:0] THR_MAX       = {THR_W{1'b1}};

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic                     i_mode = MODE_GOAL;
    logic signed [DATA_W-1:0] i_goal_angle_1 = '0;
    logic signed [DATA_W-1:0] i_goal_angle_2 = '0;
    logic signed [DATA_W-1:0] i_joint_angle_1 = '0;
    logic signed [DATA_W-1:0] i_joint_angle_2 = '0;
    logic signed [DATA_W-1:0] i_joint_rate_1 = '0;
    logic signed [DATA_W-1:0] i_joint_rate_2 = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [OUT_W-1:0]  o_drive_1;
    logic signed [OUT_W-1:0]  o_drive_2;
    logic                     o_key_press;

    drive_scoreboard sb = new();
    pd_command_t     got_cmd;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    int              hold_asked = 0;
    int              hold_served = 0;
    int              hold_left = 0;
    int              sent_items = 0;
    int              cycles = 0;

    two_joint_pd_goal_controller_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_goal_angle_1  (i_goal_angle_1),
        .i_goal_angle_2  (i_goal_angle_2),
        .i_joint_angle_1 (i_joint_angle_1),
        .i_joint_angle_2 (i_joint_angle_2),
        .i_joint_rate_1  (i_joint_rate_1),
        .i_joint_rate_2  (i_joint_rate_2),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_drive_1       (o_drive_1),
        .o_drive_2       (o_drive_2),
        .o_key_press     (o_key_press)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Taken results are checked; a long hold-off lets the pipeline fill so that the input side stalls.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_cmd.drive_1   = o_drive_1;
            got_cmd.drive_2   = o_drive_2;
            got_cmd.key_press = o_key_press;
            sb.check_drive(got_cmd);
        end
        if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic logic [CFG_DATA_W-1:0] pad_upper(logic [GAIN_W-1:0] v);
        logic [31:0] r;
        r = $urandom;
        return {r[CFG_DATA_W-GAIN_W-1:0], v};
    endfunction

    function automatic logic [THR_W-1:0] rand_thr();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[THR_W-1:0];
    endfunction

    function automatic int scatter(int spread);
        return int'($urandom_range(2 * spread)) - spread;
    endfunction

    function automatic pd_beat_t make_beat(logic mode, int g1, int g2, int a1, int a2,
                                           int r1, int r2);
        pd_beat_t b;
        b.mode          = mode;
        b.goal_angle_1  = DATA_W'(g1);
        b.goal_angle_2  = DATA_W'(g2);
        b.joint_angle_1 = DATA_W'(a1);
        b.joint_angle_2 = DATA_W'(a2);
        b.joint_rate_1  = DATA_W'(r1);
        b.joint_rate_2  = DATA_W'(r2);
        return b;
    endfunction

    function automatic pd_beat_t random_beat();
        return make_beat(1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom);
    endfunction

    task automatic offer(input pd_beat_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_mode          <= b.mode;
        i_goal_angle_1  <= b.goal_angle_1;
        i_goal_angle_2  <= b.goal_angle_2;
        i_joint_angle_1 <= b.joint_angle_1;
        i_joint_angle_2 <= b.joint_angle_2;
        i_joint_rate_1  <= b.joint_rate_1;
        i_joint_rate_2  <= b.joint_rate_2;
        do @(posedge i_clk); while (o_in_stall);
        void'(sb.note_beat(b));
        sent_items++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending_drives.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_register(idx, data);
    endtask

    task automatic program_regs(input logic [GAIN_W-1:0] gp1, input logic [GAIN_W-1:0] gp2,
                                input logic [GAIN_W-1:0] gd1, input logic [GAIN_W-1:0] gd2,
                                input logic [THR_W-1:0] vel_thr,
                                input logic [THR_W-1:0] err_thr,
                                input logic [DATA_W-1:0] tr1, input logic [DATA_W-1:0] tr2);
        settle();
        write_reg(REG_GAIN_P_1, pad_upper(gp1));
        write_reg(REG_GAIN_P_2, pad_upper(gp2));
        write_reg(REG_GAIN_D_1, pad_upper(gd1));
        write_reg(REG_GAIN_D_2, pad_upper(gd2));
        write_reg(REG_VEL_THRESH_SQ, vel_thr);
        write_reg(REG_ERR_THRESH_SQ, err_thr);
        write_reg(REG_TARGET_RATE_1, pad_upper(tr1));
        write_reg(REG_TARGET_RATE_2, pad_upper(tr2));
        write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, int'(REG_TARGET_RATE_2) + 1)),
                  rand_thr());
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly a goal followed by samples that close in on it, with some noise.
    task automatic run_phase(input int quota);
        pd_beat_t b;
        int       start_count, spread, aim_1, aim_2;
        start_count = sent_items;
        while (sent_items - start_count < quota) begin
            b = random_beat();
            if ($urandom_range(99) < 15) begin
                offer(b);
            end else begin
                b.mode = MODE_GOAL;
                if ($urandom_range(1)) begin
                    b.goal_angle_1 = DATA_W'(scatter(2048));
                    b.goal_angle_2 = DATA_W'(scatter(2048));
                end
                aim_1 = int'(b.goal_angle_1);
                aim_2 = int'(b.goal_angle_2);
                offer(b);
                spread = $urandom_range(8192, 8);
                repeat ($urandom_range(12, 2)) begin
                    b = random_beat();
                    b.mode = MODE_SAMPLE;
                    if ($urandom_range(7) == 0) begin
                        b.joint_angle_1 = DATA_W'(aim_1);
                        b.joint_angle_2 = DATA_W'(aim_2);
                        b.joint_rate_1  = '0;
                        b.joint_rate_2  = '0;
                    end else begin
                        b.joint_angle_1 = DATA_W'(aim_1 + scatter(spread));
                        b.joint_angle_2 = DATA_W'(aim_2 + scatter(spread));
                        b.joint_rate_1  = DATA_W'(scatter(spread));
                        b.joint_rate_2  = DATA_W'(scatter(spread));
                    end
                    offer(b);
                    spread = (spread > 1) ? spread / 2 : 1;
                end
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        offer(make_beat(MODE_SAMPLE, 0, 0, -32768, 32767, -32768, 32767));
        offer(make_beat(MODE_GOAL, 100, -100, 0, 0, 0, 0));
        offer(make_beat(MODE_SAMPLE, 0, 0, 0, 0, 5, -5));

        program_regs(16'hFFFF, 16'd5120, 16'hFFFF, 16'd0, '0, '0, 16'sd32767, -16'sd32768);
        offer(make_beat(MODE_GOAL, 32767, -32768, 0, 0, 0, 0));
        offer(make_beat(MODE_SAMPLE, 0, 0, -32768, 32767, 32767, 32767));
        offer(make_beat(MODE_SAMPLE, 0, 0, 32767, -32768, -32768, 0));
        offer(make_beat(MODE_SAMPLE, 0, 0, 32767, -32768, 0, 0));
        offer(make_beat(MODE_SAMPLE, 0, 0, 1, -1, 1, -1));
        offer(make_beat(MODE_GOAL, 0, 0, 0, 0, 0, 0));
        offer(make_beat(MODE_GOAL, -1, 1, 0, 0, 0, 0));
        offer(make_beat(MODE_SAMPLE, 0, 0, 0, 1, 0, 0));
        offer(make_beat(MODE_SAMPLE, 0, 0, -1, 1, 0, 0));

        send_idle_pct = 7;
        recv_idle_pct = 76;
        program_regs(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                     GAIN_W'($urandom), '0, '0, DATA_W'($urandom), DATA_W'($urandom));
        run_phase(PHASE_ITEMS);
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, THR_MAX, THR_MAX,
                     16'sd32767, -16'sd32768);
        hold_asked++;
        run_phase(PHASE_ITEMS);

        send_idle_pct = 76;
        recv_idle_pct = 7;
        program_regs('0, '0, '0, '0, 34'd40000, 34'd40000, -16'sd32768, 16'sd32767);
        run_phase(PHASE_ITEMS);
        program_regs(GAIN_W'($urandom_range(2047)), GAIN_W'($urandom_range(2047)),
                     GAIN_W'($urandom_range(2047)), GAIN_W'($urandom_range(2047)),
                     THR_W'($urandom_range(1 << 20)), THR_W'($urandom_range(1 << 20)),
                     DATA_W'(scatter(256)), DATA_W'(scatter(256)));
        run_phase(PHASE_ITEMS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_regs(GAIN_P_RESET, GAIN_P_RESET, GAIN_D_RESET, GAIN_D_RESET,
                     34'd20000, 34'd5000, '0, '0);
        hold_asked++;
        run_phase(PHASE_ITEMS);
        program_regs(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                     GAIN_W'($urandom),
                     rand_thr() >> $urandom_range(THR_W - 1),
                     rand_thr() >> $urandom_range(THR_W - 1),
                     DATA_W'($urandom), DATA_W'($urandom));
        run_phase(PHASE_ITEMS);

        settle();
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== two_joint_pd_goal_controller_unit.f =====
rtl/core/tjpd_pkg.sv
rtl/core/two_joint_pd_goal_controller_unit.sv
rtl/core/tjpd_checker.sv
sim/pd_check_pkg.sv
sim/tb_top.sv
